[rtl/robin_hood_hash_table_top_defines.svh]
// assertion macros for the robin hood hash table checker
// used by rhh_checker only; needs a clk and arst_n in the scope of use
`ifndef ROBIN_HOOD_HASH_TABLE_TOP_DEFINES_SVH
`define ROBIN_HOOD_HASH_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define RHH_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rhh assertion failed");

// next-cycle implication
`define RHH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rhh assertion failed");

`endif

[rtl/rhh_pkg.sv]
// shared types and constants of the robin hood hash table
// no dependencies
package rhh_pkg;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_READ,
		S_CHECK,
		S_FIN
	} state_t;

	typedef struct packed {
		logic start;
		logic step;
	} hash_ctl_t;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_FOUND    = 2'd1;
	localparam logic [1:0] ST_ABSENT   = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam logic        KIND_INSERT = 1'b0;
	localparam logic [31:0] HASH_SEED   = 32'd5381;
	localparam int          HASH_SHIFT  = 5;
	localparam int          TABLE_BITS_RESET = 10;

endpackage

[rtl/rhh_hash.sv]
// djb2 hash unit, one key byte per cycle while ctl.step is set, keeps only the low W bits
// depends on rhh_pkg
module rhh_hash import rhh_pkg::*; #(
	parameter int W = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  hash_ctl_t    ctl,
	input  logic [7:0]   data_byte,
	output logic [W-1:0] hash
);

	logic [W+7:0] sum;
	logic [W-1:0] h_q;

	// h*33 + byte, upper bits never reach the masked index
	assign sum = ({8'b0, h_q} << HASH_SHIFT) + {8'b0, h_q} + {{W{1'b0}}, data_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= HASH_SEED[W-1:0];
		end else if (ctl.start) begin
			h_q <= HASH_SEED[W-1:0];
		end else if (ctl.step) begin
			h_q <= sum[W-1:0];
		end
	end

	assign hash = h_q;

endmodule

[rtl/robin_hood_hash_table_top.sv]
// robin hood hash table, top level: sequencer, slot memory, result register
// sequence: hash the key bytes, then read and check each probed slot, then register the result
// throughput: one item at a time; the probe walk over the slot memory sets it
// reset and every table_bits write start a clearing pass over all 2^MAX_TABLE_BITS slots
// during which no item is accepted; depends on rhh_pkg and rhh_hash
module robin_hood_hash_table_top import rhh_pkg::*; #(
	parameter int MAX_TABLE_BITS = 10,
	parameter int KEY_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [63:0] key_bytes,
	input  logic [3:0]  key_len,
	input  logic [31:0] entry_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] found_value
);

	localparam int M = MAX_TABLE_BITS;
	localparam int SLOTS = 1 << M;
	localparam int TB_W = $clog2(M + 1);
	localparam int TB_RST = (TABLE_BITS_RESET > M) ? M : TABLE_BITS_RESET;
	localparam int ENT_W = 1 + M + 32 + 4 + 64;

	state_t state_q, state_d;

	logic [TB_W-1:0] tb_q;
	logic [M:0]      count_q;
	logic [M-1:0]    clr_q;
	logic [M:0]      size;
	logic [M-1:0]    mask;

	// carried entry and walk registers
	logic            kind_q;
	logic [63:0]     ckey_q;
	logic [3:0]      clen_q;
	logic [31:0]     cval_q;
	logic [M-1:0]    chome_q;
	logic [M:0]      dist_q;
	logic [M-1:0]    idx_q;
	logic [M:0]      step_q;
	logic [3:0]      bcnt_q;
	logic [1:0]      rstat_q;
	logic [31:0]     rval_q;

	logic [1:0]      status_q;
	logic [31:0]     found_q;
	logic            ov_q;

	// slot memory
	logic [ENT_W-1:0] mem [SLOTS];
	logic [ENT_W-1:0] rd_q;
	logic             mem_we;
	logic [M-1:0]     mem_waddr;
	logic [ENT_W-1:0] mem_wdata;

	hash_ctl_t    hctl;
	logic [M-1:0] hash;
	logic [7:0]   hbyte;

	logic         r_valid;
	logic [M-1:0] r_home;
	logic [31:0]  r_val;
	logic [3:0]   r_len;
	logic [63:0]  r_key;
	logic [M-1:0] d_in;
	logic         match;
	logic         in_acc;
	logic         last_step;
	logic [3:0]   len_c;
	logic [63:0]  key_m;

	assign size = (M + 1)'(1) << tb_q;
	assign mask = size[M-1:0] - M'(1);

	assign {r_valid, r_home, r_val, r_len, r_key} = rd_q;
	assign d_in = (idx_q - r_home) & mask;
	assign match = (r_len == clen_q) && (r_key == ckey_q);
	assign last_step = (step_q + (M + 1)'(1)) == size;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;

	// clamp length and drop bytes past it
	always_comb begin
		len_c = (key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_len;
		for (int b = 0; b < 8; b++) begin
			key_m[b*8 +: 8] = (4'(b) < len_c) ? key_bytes[b*8 +: 8] : 8'h00;
		end
	end

	assign hbyte = ckey_q[{bcnt_q[2:0], 3'b000} +: 8];

	rhh_hash #(.W(M)) u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (hctl),
		.data_byte (hbyte),
		.hash      (hash)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == M'(SLOTS - 1)) state_d = S_IDLE;
			S_IDLE:  if (in_acc) state_d = S_HASH;
			S_HASH: begin
				if (bcnt_q == clen_q) begin
					if (kind_q == KIND_INSERT && count_q >= size) state_d = S_FIN;
					else state_d = S_READ;
				end
			end
			S_READ:  state_d = S_CHECK;
			S_CHECK: begin
				if (kind_q == KIND_INSERT) begin
					state_d = r_valid ? S_READ : S_FIN;
				end else if (!r_valid || match || dist_q > {1'b0, d_in} || last_step) begin
					state_d = S_FIN;
				end else begin
					state_d = S_READ;
				end
			end
			S_FIN:   if (!ov_q || out_ready) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
		if (cfg_we) state_d = S_CLEAR;
	end

	// control outputs
	always_comb begin
		hctl = '0;
		mem_we = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = {1'b1, chome_q, cval_q, clen_q, ckey_q};
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_IDLE:  hctl.start = 1'b1;
			S_HASH:  hctl.step = (bcnt_q != clen_q);
			S_CHECK: begin
				mem_we = (kind_q == KIND_INSERT) && (!r_valid || {1'b0, d_in} < dist_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			tb_q    <= TB_W'(TB_RST);
			count_q <= '0;
			clr_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_wdata == 4'd0) tb_q <= TB_W'(1);
				else if ({1'b0, cfg_wdata} > 5'(M)) tb_q <= TB_W'(M);
				else tb_q <= TB_W'(cfg_wdata);
				count_q <= '0;
				clr_q <= '0;
			end else begin
				if (state_q == S_CLEAR) clr_q <= clr_q + M'(1);
				if (state_q == S_CHECK && kind_q == KIND_INSERT && !r_valid)
					count_q <= count_q + (M + 1)'(1);
			end
			if (state_q == S_FIN && (!ov_q || out_ready)) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				kind_q  <= kind;
				ckey_q  <= key_m;
				clen_q  <= len_c;
				cval_q  <= entry_value;
				bcnt_q  <= '0;
				dist_q  <= '0;
				step_q  <= '0;
				rstat_q <= ST_ABSENT;
				rval_q  <= '0;
			end
			S_HASH: begin
				if (bcnt_q != clen_q) begin
					bcnt_q <= bcnt_q + 4'd1;
				end else begin
					idx_q   <= hash & mask;
					chome_q <= hash & mask;
					if (kind_q == KIND_INSERT) rstat_q <= ST_FULL;
				end
			end
			S_CHECK: begin
				idx_q  <= (idx_q + M'(1)) & mask;
				step_q <= step_q + (M + 1)'(1);
				dist_q <= dist_q + (M + 1)'(1);
				if (kind_q == KIND_INSERT) begin
					if (!r_valid) begin
						rstat_q <= ST_INSERTED;
					end else if ({1'b0, d_in} < dist_q) begin
						// swap: carry the richer resident onward
						ckey_q  <= r_key;
						clen_q  <= r_len;
						cval_q  <= r_val;
						chome_q <= r_home;
						dist_q  <= {1'b0, d_in} + (M + 1)'(1);
					end
				end else if (r_valid && match) begin
					rstat_q <= ST_FOUND;
					rval_q  <= r_val;
				end
			end
			S_FIN: begin
				if (!ov_q || out_ready) begin
					status_q <= rstat_q;
					found_q  <= rval_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = ov_q;
	assign status = status_q;
	assign found_value = found_q;

endmodule

[rtl/rhh_checker.sv]
// port-level checker for the robin hood hash table, bound to the top level
// depends on rhh_pkg and robin_hood_hash_table_top_defines.svh
`include "robin_hood_hash_table_top_defines.svh"

module rhh_checker import rhh_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [31:0] found_value
);

	// a waiting result holds
	`RHH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(found_value))
	// only a hit carries a value
	`RHH_ASSERT_NOW(a_value_zero, out_valid && status != ST_FOUND, found_value == 32'd0)
	// an accepted item keeps the block busy
	`RHH_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)

endmodule

bind robin_hood_hash_table_top rhh_checker u_rhh_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.found_value (found_value)
);
